[src/tcts_pkg.sv]
// Shared widths, item types and queue sizing for the tangent segment block.
package tcts_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRAC_BITS     = 8;
  localparam int RAD_BITS      = COORD_BITS - 1;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int ADJ_BITS      = COORD_BITS + 2;
  localparam int D2_BITS       = 2 * COORD_BITS + 2;
  localparam int RADICAND_BITS = D2_BITS + 2 * FRAC_BITS;
  localparam int ROOT_BITS     = RADICAND_BITS / 2;
  localparam int AX_BITS       = DIFF_BITS + ADJ_BITS;
  localparam int PS_BITS       = DIFF_BITS + ROOT_BITS + 1;
  localparam int NUM_BITS      = D2_BITS + FRAC_BITS + 1;
  localparam int WIDE_BITS     = NUM_BITS + 1;
  localparam int MAG_BITS      = NUM_BITS - 1;
  localparam int SPLIT_BITS    = MAG_BITS / 2;
  localparam int PROD_BITS     = MAG_BITS + RAD_BITS;
  localparam int QUO_BITS      = RAD_BITS + FRAC_BITS + 1;
  localparam int OUT_BITS      = COORD_BITS + 1 + FRAC_BITS;
  localparam int NUM_DIV       = 8;

  localparam int QUEUE_DEPTH   = 4;
  localparam int PTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_BITS    = PTR_BITS + 1;
  localparam int FRONT_STAGES  = 3;
  localparam int OCC_BITS      = $clog2(FRONT_STAGES + 1);

  // Classified item handed from the front part to the back part
  typedef struct packed {
    logic signed [COORD_BITS-1:0]  c1x;
    logic signed [COORD_BITS-1:0]  c1y;
    logic signed [COORD_BITS-1:0]  c2x;
    logic signed [COORD_BITS-1:0]  c2y;
    logic [RAD_BITS-1:0]           r1;
    logic [RAD_BITS-1:0]           r2;
    logic                          inner;
    logic                          found;
    logic signed [DIFF_BITS-1:0]   hx;
    logic signed [DIFF_BITS-1:0]   hy;
    logic signed [ADJ_BITS-1:0]    adj;
    logic [D2_BITS-1:0]            d2;
    logic [RADICAND_BITS-1:0]      rad;
  } front_item_t;

  // Fields the output stage needs, carried beside the dividers
  typedef struct packed {
    logic signed [COORD_BITS-1:0]  c1x;
    logic signed [COORD_BITS-1:0]  c1y;
    logic signed [COORD_BITS-1:0]  c2x;
    logic signed [COORD_BITS-1:0]  c2y;
    logic                          inner;
    logic                          found;
    logic [3:0]                    sgn;
  } side_t;

endpackage

[src/tcts_front.sv]
// Front part: takes items, forms differences, squared distances and the existence test.
module tcts_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic signed [tcts_pkg::COORD_BITS-1:0] c1x,
  input  logic signed [tcts_pkg::COORD_BITS-1:0] c1y,
  input  logic [tcts_pkg::RAD_BITS-1:0]      r1,
  input  logic signed [tcts_pkg::COORD_BITS-1:0] c2x,
  input  logic signed [tcts_pkg::COORD_BITS-1:0] c2y,
  input  logic [tcts_pkg::RAD_BITS-1:0]      r2,
  input  logic                               inner,
  output logic                               out_valid,
  output tcts_pkg::front_item_t              out_item,
  output logic [tcts_pkg::OCC_BITS-1:0]      occupancy
);
  import tcts_pkg::*;

  logic        v1, v2, v3;
  front_item_t s1, s2, s3;
  front_item_t s1_next, s2_next, s3_next;
  logic signed [2*DIFF_BITS-1:0] sqx, sqy;
  logic signed [2*ADJ_BITS-1:0]  sqa;

  // Stage 1: capture and form center differences and radius combination
  always_comb begin
    s1_next       = '0;
    s1_next.c1x   = c1x;
    s1_next.c1y   = c1y;
    s1_next.c2x   = c2x;
    s1_next.c2y   = c2y;
    s1_next.r1    = r1;
    s1_next.r2    = r2;
    s1_next.inner = inner;
    s1_next.hx    = DIFF_BITS'(c2x) - DIFF_BITS'(c1x);
    s1_next.hy    = DIFF_BITS'(c2y) - DIFF_BITS'(c1y);
    if (inner) begin
      s1_next.adj = $signed(ADJ_BITS'(r1)) + $signed(ADJ_BITS'(r2));
    end else begin
      s1_next.adj = $signed(ADJ_BITS'(r1)) - $signed(ADJ_BITS'(r2));
    end
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
  end

  // Stage 2: squared distance and squared radius combination
  always_comb begin
    sqx = s1.hx * s1.hx;
    sqy = s1.hy * s1.hy;
    sqa = s1.adj * s1.adj;
    s2_next     = s1;
    s2_next.d2  = D2_BITS'(sqx) + D2_BITS'(sqy);
    s2_next.rad = RADICAND_BITS'(sqa[D2_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    s2 <= s2_next;
  end

  // Stage 3: existence test and scaled radicand
  always_comb begin
    s3_next       = s2;
    s3_next.found = s2.d2 > s2.rad[D2_BITS-1:0];
    s3_next.rad   = RADICAND_BITS'(s2.d2 - s2.rad[D2_BITS-1:0]) << (2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    s3 <= s3_next;
  end

  // Track valid items through the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign out_valid = v3;
  assign out_item  = s3;
  assign occupancy = OCC_BITS'(v1) + OCC_BITS'(v2) + OCC_BITS'(v3);

endmodule

[src/tcts_queue.sv]
// Short queue between the front and back parts; drains one item per cycle.
module tcts_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  tcts_pkg::front_item_t             push_item,
  output logic                              out_valid,
  output tcts_pkg::front_item_t             out_item,
  output logic [tcts_pkg::LEVEL_BITS-1:0]   level
);
  import tcts_pkg::*;

  front_item_t          slots [0:QUEUE_DEPTH-1];
  logic [PTR_BITS-1:0]  wptr, rptr;
  logic [LEVEL_BITS-1:0] count;
  logic                 pop;

  assign pop       = count != '0;
  assign out_valid = pop;
  assign out_item  = slots[rptr];
  assign level     = count;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + LEVEL_BITS'(push) - LEVEL_BITS'(pop);
    end
  end

endmodule

[src/tcts_sqrt.sv]
// Pipelined integer square root, one result bit per stage, carrying the item along.
module tcts_sqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  tcts_pkg::front_item_t            in_item,
  output logic                             out_valid,
  output tcts_pkg::front_item_t            out_item,
  output logic [tcts_pkg::ROOT_BITS-1:0]   out_root
);
  import tcts_pkg::*;

  front_item_t              itm  [0:ROOT_BITS];
  logic [RADICAND_BITS-1:0] rad  [0:ROOT_BITS];
  logic [ROOT_BITS:0]       rem  [0:ROOT_BITS];
  logic [ROOT_BITS-1:0]     root [0:ROOT_BITS];
  logic                     vld  [0:ROOT_BITS];

  assign itm[0]  = in_item;
  assign rad[0]  = in_item.rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign vld[0]  = in_valid;

  for (genvar k = 1; k <= ROOT_BITS; k++) begin : g_stage
    logic [ROOT_BITS+2:0] cur, trial;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      cur   = {rem[k-1], rad[k-1][RADICAND_BITS-1 -: 2]};
      trial = {1'b0, root[k-1], 2'b01};
    end

    always_ff @(posedge clk) begin
      itm[k] <= itm[k-1];
      rad[k] <= rad[k-1] << 2;
      if (cur >= trial) begin
        rem[k]  <= (ROOT_BITS+1)'(cur - trial);
        root[k] <= {root[k-1][ROOT_BITS-2:0], 1'b1};
      end else begin
        rem[k]  <= (ROOT_BITS+1)'(cur);
        root[k] <= {root[k-1][ROOT_BITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end
  end

  assign out_valid = vld[ROOT_BITS];
  assign out_item  = itm[ROOT_BITS];
  assign out_root  = root[ROOT_BITS];

endmodule

[src/tcts_div.sv]
// Pipelined restoring divider, one quotient bit per stage, keeps the final remainder.
module tcts_div (
  input  logic                            clk,
  input  logic [tcts_pkg::PROD_BITS-1:0]  in_prod,
  input  logic [tcts_pkg::D2_BITS-1:0]    in_d2,
  output logic [tcts_pkg::QUO_BITS-1:0]   out_quo,
  output logic [tcts_pkg::D2_BITS-1:0]    out_rem,
  output logic [tcts_pkg::D2_BITS-1:0]    out_d2
);
  import tcts_pkg::*;

  logic [D2_BITS-1:0]  rem [0:QUO_BITS];
  logic [QUO_BITS-1:0] low [0:QUO_BITS];
  logic [QUO_BITS-1:0] quo [0:QUO_BITS];
  logic [D2_BITS-1:0]  den [0:QUO_BITS];

  // The quotient is known to fit, so the upper product bits start below the divisor
  assign rem[0] = D2_BITS'(in_prod[PROD_BITS-1:QUO_BITS]);
  assign low[0] = in_prod[QUO_BITS-1:0];
  assign quo[0] = '0;
  assign den[0] = in_d2;

  for (genvar k = 1; k <= QUO_BITS; k++) begin : g_stage
    logic [D2_BITS:0] cur;
    logic             ge;

    // Shift in the next dividend bit and subtract where it fits
    always_comb begin
      cur = {rem[k-1], low[k-1][QUO_BITS-1]};
      ge  = cur >= {1'b0, den[k-1]};
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? D2_BITS'(cur - {1'b0, den[k-1]}) : D2_BITS'(cur);
      low[k] <= low[k-1] << 1;
      quo[k] <= {quo[k-1][QUO_BITS-2:0], ge};
      den[k] <= den[k-1];
    end
  end

  assign out_quo = quo[QUO_BITS];
  assign out_rem = rem[QUO_BITS];
  assign out_d2  = den[QUO_BITS];

endmodule

[src/tcts_back.sv]
// Back part: square root, tangent numerators, scaled divisions and rounded segment ends.
module tcts_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  tcts_pkg::front_item_t                in_item,
  output logic                                 done,
  output logic                                 found,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_a_start_x,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_a_start_y,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_a_end_x,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_a_end_y,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_b_start_x,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_b_start_y,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_b_end_x,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_b_end_y
);
  import tcts_pkg::*;

  localparam int HI_BITS = MAG_BITS - SPLIT_BITS;

  // Entry register
  logic        v0;
  front_item_t item0;

  // Square root output
  logic                 sq_valid;
  front_item_t          sq_item;
  logic [ROOT_BITS-1:0] sq_root;
  logic signed [ROOT_BITS:0] sroot;

  // Product stage
  logic                       v1;
  logic signed [AX_BITS-1:0]  ax1, ay1;
  logic signed [PS_BITS-1:0]  hys1, hxs1;
  logic [D2_BITS-1:0]         d2_1;
  logic [RAD_BITS-1:0]        r1_1, r2_1;
  side_t                      side1;

  // Numerator stage
  logic signed [WIDE_BITS-1:0] axw, ayw, hysw, hxsw;
  logic signed [WIDE_BITS-1:0] num [0:3];
  side_t                       side_n;
  logic                        v2;
  logic [MAG_BITS-1:0]         mag2 [0:3];
  logic [D2_BITS-1:0]          d2_2;
  logic [RAD_BITS-1:0]         r1_2, r2_2;
  side_t                       side2;

  // Partial product stages
  logic                            v3, v4;
  logic [HI_BITS+RAD_BITS-1:0]     hi3 [0:NUM_DIV-1];
  logic [SPLIT_BITS+RAD_BITS-1:0]  lo3 [0:NUM_DIV-1];
  logic [PROD_BITS-1:0]            p4  [0:NUM_DIV-1];
  logic [D2_BITS-1:0]              d2_3, d2_4;
  side_t                           side3, side4;

  // Divider outputs and the side line beside them
  logic [QUO_BITS-1:0] quo  [0:NUM_DIV-1];
  logic [D2_BITS-1:0]  rem  [0:NUM_DIV-1];
  logic [D2_BITS-1:0]  dden [0:NUM_DIV-1];
  side_t               sidep [0:QUO_BITS-1];
  logic                vp    [0:QUO_BITS-1];

  // Output rounding
  logic signed [OUT_BITS-1:0] res [0:NUM_DIV-1];
  side_t                      sd;

  // Hold the item from the queue
  always_ff @(posedge clk) begin
    item0 <= in_item;
  end

  tcts_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_item   (item0),
    .out_valid (sq_valid),
    .out_item  (sq_item),
    .out_root  (sq_root)
  );

  assign sroot = $signed({1'b0, sq_root});

  // Form h*adj and h*S products
  always_ff @(posedge clk) begin
    ax1        <= sq_item.hx * sq_item.adj;
    ay1        <= sq_item.hy * sq_item.adj;
    hys1       <= sq_item.hy * sroot;
    hxs1       <= sq_item.hx * sroot;
    d2_1       <= sq_item.d2;
    r1_1       <= sq_item.r1;
    r2_1       <= sq_item.r2;
    side1.c1x  <= sq_item.c1x;
    side1.c1y  <= sq_item.c1y;
    side1.c2x  <= sq_item.c2x;
    side1.c2y  <= sq_item.c2y;
    side1.inner <= sq_item.inner;
    side1.found <= sq_item.found;
    side1.sgn  <= '0;
  end

  // Combine into the four numerators (segment a x/y, segment b x/y)
  always_comb begin
    axw    = {{(WIDE_BITS-AX_BITS){ax1[AX_BITS-1]}}, ax1} <<< FRAC_BITS;
    ayw    = {{(WIDE_BITS-AX_BITS){ay1[AX_BITS-1]}}, ay1} <<< FRAC_BITS;
    hysw   = {{(WIDE_BITS-PS_BITS){hys1[PS_BITS-1]}}, hys1};
    hxsw   = {{(WIDE_BITS-PS_BITS){hxs1[PS_BITS-1]}}, hxs1};
    num[0] = axw + hysw;
    num[1] = ayw - hxsw;
    num[2] = axw - hysw;
    num[3] = ayw + hxsw;
    side_n     = side1;
    side_n.sgn = {num[3][WIDE_BITS-1], num[2][WIDE_BITS-1],
                  num[1][WIDE_BITS-1], num[0][WIDE_BITS-1]};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (num[i][WIDE_BITS-1]) begin
        mag2[i] <= MAG_BITS'(-num[i]);
      end else begin
        mag2[i] <= MAG_BITS'(num[i]);
      end
    end
    d2_2  <= d2_1;
    r1_2  <= r1_1;
    r2_2  <= r2_1;
    side2 <= side_n;
  end

  // Multiply each magnitude by each radius in two halves
  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_DIV; j++) begin
      if (j % 2 == 1) begin
        hi3[j] <= mag2[j/2][MAG_BITS-1:SPLIT_BITS] * r2_2;
        lo3[j] <= mag2[j/2][SPLIT_BITS-1:0] * r2_2;
      end else begin
        hi3[j] <= mag2[j/2][MAG_BITS-1:SPLIT_BITS] * r1_2;
        lo3[j] <= mag2[j/2][SPLIT_BITS-1:0] * r1_2;
      end
    end
    d2_3  <= d2_2;
    side3 <= side2;
  end

  // Sum the halves
  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_DIV; j++) begin
      p4[j] <= (PROD_BITS'(hi3[j]) << SPLIT_BITS) + PROD_BITS'(lo3[j]);
    end
    d2_4  <= d2_3;
    side4 <= side3;
  end

  for (genvar j = 0; j < NUM_DIV; j++) begin : g_div
    tcts_div u_div (
      .clk     (clk),
      .in_prod (p4[j]),
      .in_d2   (d2_4),
      .out_quo (quo[j]),
      .out_rem (rem[j]),
      .out_d2  (dden[j])
    );
  end

  // Carry side fields alongside the dividers
  always_ff @(posedge clk) begin
    sidep[0] <= side4;
    for (int k = 1; k < QUO_BITS; k++) begin
      sidep[k] <= sidep[k-1];
    end
  end

  assign sd = sidep[QUO_BITS-1];

  // Round to nearest, apply sign and add the scaled center
  for (genvar j = 0; j < NUM_DIV; j++) begin : g_round
    logic                        inc, neg;
    logic [QUO_BITS:0]           off;
    logic signed [OUT_BITS+1:0]  soff, base, sum;
    logic signed [COORD_BITS-1:0] cen;

    always_comb begin
      inc = {rem[j], 1'b0} >= {1'b0, dden[j]};
      off = (QUO_BITS+1)'(quo[j]) + (QUO_BITS+1)'(inc);
      neg = sd.sgn[j/4*2 + (j/2)%2] ^ ((j % 2 == 1) && sd.inner);
      soff = neg ? -$signed((OUT_BITS+2)'(off)) : $signed((OUT_BITS+2)'(off));
      case (j % 4)
        0:       cen = sd.c1x;
        1:       cen = sd.c2x;
        2:       cen = sd.c1y;
        default: cen = sd.c2y;
      endcase
      base = {{(OUT_BITS+2-COORD_BITS){cen[COORD_BITS-1]}}, cen} <<< FRAC_BITS;
      sum  = base + soff;
      res[j] = sd.found ? sum[OUT_BITS-1:0] : '0;
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    found         <= sd.found;
    seg_a_start_x <= res[0];
    seg_a_end_x   <= res[1];
    seg_a_start_y <= res[2];
    seg_a_end_y   <= res[3];
    seg_b_start_x <= res[4];
    seg_b_end_x   <= res[5];
    seg_b_start_y <= res[6];
    seg_b_end_y   <= res[7];
  end

  // Track valid items through the back stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
      for (int k = 0; k < QUO_BITS; k++) begin
        vp[k] <= 1'b0;
      end
    end else begin
      v0    <= in_valid;
      v1    <= sq_valid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      vp[0] <= v4;
      for (int k = 1; k < QUO_BITS; k++) begin
        vp[k] <= vp[k-1];
      end
      done <= vp[QUO_BITS-1];
    end
  end

endmodule

[src/two_circle_tangent_segments.sv]
// Top level: common tangent segments of two circles, front part, queue and back part.
//
//  channel   handshake         payload
//  input     start / busy      first_*, second_*, want_inner
//  result    done (one cycle)  found, seg_a_*, seg_b_*
//
// One item per cycle is accepted while busy is low; each result passes through
// the front stages, the queue, the entry register, the square root stages,
// the product stages, the divider stages and the output register.
// Rate is set by the fully pipelined square root and the eight dividers.
// Synchronous reset clears all valid flags and the queue pointers.
// The receiver cannot stall; busy rises only if the queue could overflow.
module two_circle_tangent_segments (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tcts_pkg::COORD_BITS-1:0] first_center_x,
  input  logic signed [tcts_pkg::COORD_BITS-1:0] first_center_y,
  input  logic [tcts_pkg::RAD_BITS-1:0]        first_radius,
  input  logic signed [tcts_pkg::COORD_BITS-1:0] second_center_x,
  input  logic signed [tcts_pkg::COORD_BITS-1:0] second_center_y,
  input  logic [tcts_pkg::RAD_BITS-1:0]        second_radius,
  input  logic                                 want_inner,
  output logic                                 done,
  output logic                                 found,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_a_start_x,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_a_start_y,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_a_end_x,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_a_end_y,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_b_start_x,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_b_start_y,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_b_end_x,
  output logic signed [tcts_pkg::OUT_BITS-1:0] seg_b_end_y
);
  import tcts_pkg::*;

  logic                  accept;
  logic                  f_valid, q_valid;
  front_item_t           f_item, q_item;
  logic [OCC_BITS-1:0]   f_occ;
  logic [LEVEL_BITS-1:0] q_level;

  // Hold off new items when queue plus items in flight could overflow it
  assign busy   = ((LEVEL_BITS+1)'(q_level) + (LEVEL_BITS+1)'(f_occ))
                  > (LEVEL_BITS+1)'(QUEUE_DEPTH);
  assign accept = start && !busy;

  tcts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .c1x       (first_center_x),
    .c1y       (first_center_y),
    .r1        (first_radius),
    .c2x       (second_center_x),
    .c2y       (second_center_y),
    .r2        (second_radius),
    .inner     (want_inner),
    .out_valid (f_valid),
    .out_item  (f_item),
    .occupancy (f_occ)
  );

  tcts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .out_valid (q_valid),
    .out_item  (q_item),
    .level     (q_level)
  );

  tcts_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (q_valid),
    .in_item       (q_item),
    .done          (done),
    .found         (found),
    .seg_a_start_x (seg_a_start_x),
    .seg_a_start_y (seg_a_start_y),
    .seg_a_end_x   (seg_a_end_x),
    .seg_a_end_y   (seg_a_end_y),
    .seg_b_start_x (seg_b_start_x),
    .seg_b_start_y (seg_b_start_y),
    .seg_b_end_x   (seg_b_end_x),
    .seg_b_end_y   (seg_b_end_y)
  );

endmodule

[sim/tcts_checker.sv]
// Checker for the tangent segment block: predicts each result and compares it.
`timescale 1ns / 100ps
module tcts_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic signed [tcts_pkg::COORD_BITS-1:0] first_center_x,
  input  logic signed [tcts_pkg::COORD_BITS-1:0] first_center_y,
  input  logic [tcts_pkg::RAD_BITS-1:0]          first_radius,
  input  logic signed [tcts_pkg::COORD_BITS-1:0] second_center_x,
  input  logic signed [tcts_pkg::COORD_BITS-1:0] second_center_y,
  input  logic [tcts_pkg::RAD_BITS-1:0]          second_radius,
  input  logic                                   want_inner,
  input  logic                                   done,
  input  logic                                   found,
  input  logic [tcts_pkg::OUT_BITS-1:0]          seg_a_start_x,
  input  logic [tcts_pkg::OUT_BITS-1:0]          seg_a_start_y,
  input  logic [tcts_pkg::OUT_BITS-1:0]          seg_a_end_x,
  input  logic [tcts_pkg::OUT_BITS-1:0]          seg_a_end_y,
  input  logic [tcts_pkg::OUT_BITS-1:0]          seg_b_start_x,
  input  logic [tcts_pkg::OUT_BITS-1:0]          seg_b_start_y,
  input  logic [tcts_pkg::OUT_BITS-1:0]          seg_b_end_x,
  input  logic [tcts_pkg::OUT_BITS-1:0]          seg_b_end_y,
  output int                                     fail_count,
  output int                                     pending
);
  import tcts_pkg::*;

  localparam int NUM_COORDS = 8;

  typedef struct {
    logic                found;
    logic [OUT_BITS-1:0] coord [NUM_COORDS];
  } tangent_t;

  tangent_t tangent_q [$];

  // Integer square root, floor, bit by bit
  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Round r*num/d2 to nearest, ties away from zero
  function automatic longint signed round_offset(longint signed num, longint unsigned r,
                                                  longint unsigned d2);
    longint unsigned mag, p, q, rm;
    mag = (num < 0) ? -num : num;
    p = mag * r;
    q = p / d2;
    rm = p % d2;
    if (rm >= d2 - rm) q++;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic tangent_t predict_tangents(longint signed c1x, c1y, longint signed r1,
                                                 longint signed c2x, c2y, longint signed r2,
                                                 logic inner);
    tangent_t t;
    longint signed hx, hy, adj, ax, ay, bx, by, ex, ey, nx, ny, rs;
    longint unsigned d2, adj2, s;
    longint signed nv [4];
    t.found = 1'b0;
    for (int k = 0; k < NUM_COORDS; k++) t.coord[k] = '0;
    hx = c2x - c1x;
    hy = c2y - c1y;
    d2 = hx * hx + hy * hy;
    adj = inner ? r1 + r2 : r1 - r2;
    adj2 = adj * adj;
    if (d2 <= adj2) return t;
    s = isqrt((d2 - adj2) << (2 * FRAC_BITS));
    ax = (hx * adj) <<< FRAC_BITS;
    ay = (hy * adj) <<< FRAC_BITS;
    bx = -(hy * longint'(s));
    by = hx * longint'(s);
    nv[0] = ax - bx; nv[1] = ay - by; nv[2] = ax + bx; nv[3] = ay + by;
    t.found = 1'b1;
    for (int k = 0; k < 2; k++) begin
      nx = nv[2 * k];
      ny = nv[2 * k + 1];
      ex = round_offset(nx, r2, d2);
      ey = round_offset(ny, r2, d2);
      if (inner) begin
        ex = -ex;
        ey = -ey;
      end
      rs = (c1x <<< FRAC_BITS) + round_offset(nx, r1, d2);
      t.coord[4 * k] = rs[OUT_BITS-1:0];
      rs = (c1y <<< FRAC_BITS) + round_offset(ny, r1, d2);
      t.coord[4 * k + 1] = rs[OUT_BITS-1:0];
      rs = (c2x <<< FRAC_BITS) + ex;
      t.coord[4 * k + 2] = rs[OUT_BITS-1:0];
      rs = (c2y <<< FRAC_BITS) + ey;
      t.coord[4 * k + 3] = rs[OUT_BITS-1:0];
    end
    return t;
  endfunction

  string coord_name [NUM_COORDS] = '{"seg_a_start_x", "seg_a_start_y", "seg_a_end_x",
    "seg_a_end_y", "seg_b_start_x", "seg_b_start_y", "seg_b_end_x", "seg_b_end_y"};

  assign pending = tangent_q.size();

  // Predict on accepted items, compare on each strobe
  always @(posedge clk) begin
    tangent_t want;
    logic [OUT_BITS-1:0] got [NUM_COORDS];
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy)
        tangent_q.push_back(predict_tangents(first_center_x, first_center_y,
          longint'({1'b0, first_radius}), second_center_x, second_center_y,
          longint'({1'b0, second_radius}), want_inner));
      if (done) begin
        got = '{seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
                seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y};
        if (tangent_q.size() == 0) begin
          $error("result with no item waiting");
          errs = errs + 1;
        end else begin
          want = tangent_q.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d actual %0d", want.found, found);
            errs = errs + 1;
          end
          for (int k = 0; k < NUM_COORDS; k++)
            if (got[k] !== want.coord[k]) begin
              $error("%s: expected %0d actual %0d", coord_name[k],
                     $signed(want.coord[k]), $signed(got[k]));
              errs = errs + 1;
            end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

[sim/testbench.sv]
// Testbench top: stimulus, clock, reset and verdict for the tangent segment block.
`timescale 1ns / 100ps
module testbench;
  import tcts_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, found;
  logic signed [COORD_BITS-1:0] c1x = '0, c1y = '0, c2x = '0, c2y = '0;
  logic [RAD_BITS-1:0] r1 = '0, r2 = '0;
  logic inner = 1'b0;
  logic signed [OUT_BITS-1:0] sax, say, sex, sey, sbx, sby, sfx, sfy;
  int fail_count, pending;
  int idle_pct;

  always #5 clk = ~clk;

  two_circle_tangent_segments i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_center_x(c1x), .first_center_y(c1y), .first_radius(r1),
    .second_center_x(c2x), .second_center_y(c2y), .second_radius(r2),
    .want_inner(inner), .done(done), .found(found),
    .seg_a_start_x(sax), .seg_a_start_y(say), .seg_a_end_x(sex), .seg_a_end_y(sey),
    .seg_b_start_x(sbx), .seg_b_start_y(sby), .seg_b_end_x(sfx), .seg_b_end_y(sfy)
  );

  tcts_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_center_x(c1x), .first_center_y(c1y), .first_radius(r1),
    .second_center_x(c2x), .second_center_y(c2y), .second_radius(r2),
    .want_inner(inner), .done(done), .found(found),
    .seg_a_start_x(sax), .seg_a_start_y(say), .seg_a_end_x(sex), .seg_a_end_y(sey),
    .seg_b_start_x(sbx), .seg_b_start_y(sby), .seg_b_end_x(sfx), .seg_b_end_y(sfy),
    .fail_count(fail_count), .pending(pending)
  );

  // Offer one item, hold it until accepted; idle beforehand per the phase
  task automatic send_item(int ax, int ay, int ar, int bx, int by, int br, bit inn);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    c1x <= COORD_BITS'(ax); c1y <= COORD_BITS'(ay); r1 <= RAD_BITS'(ar);
    c2x <= COORD_BITS'(bx); c2y <= COORD_BITS'(by); r2 <= RAD_BITS'(br);
    inner <= inn;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random item: mostly small circles with nearby centers, some full range
  task automatic send_random();
    int ax, ay, bx, by, ar, br, sel;
    sel = $urandom_range(9);
    if (sel < 6) begin
      ax = $signed($urandom_range(2000)) - 1000;
      ay = $signed($urandom_range(2000)) - 1000;
      bx = ax + $signed($urandom_range(4000)) - 2000;
      by = ay + $signed($urandom_range(4000)) - 2000;
      ar = $urandom_range(600);
      br = $urandom_range(600);
    end else begin
      ax = $signed($urandom_range(65535)) - 32768;
      ay = $signed($urandom_range(65535)) - 32768;
      bx = $signed($urandom_range(65535)) - 32768;
      by = $signed($urandom_range(65535)) - 32768;
      ar = $urandom_range(32767);
      br = $urandom_range(32767);
    end
    send_item(ax, ay, ar, bx, by, br, $urandom_range(1));
  endtask

  // Drop start and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 0;
    // Directed: extremes, both tangent kinds, nested, touching, coincident, points
    send_item(-32768, -32768, 32767, 32767, 32767, 32767, 0);
    send_item(-32768, -32768, 32767, 32767, 32767, 32767, 1);
    send_item(32767, -32768, 0, -32768, 32767, 0, 0);
    send_item(32767, -32768, 0, -32768, 32767, 0, 1);
    send_item(0, 0, 0, 0, 0, 0, 0);
    send_item(5, 5, 10, 5, 5, 10, 0);
    send_item(0, 0, 100, 10, 0, 5, 0);
    send_item(0, 0, 10, 20, 0, 10, 1);
    send_item(0, 0, 10, 15, 0, 5, 0);
    send_item(0, 0, 10, 30, 0, 10, 1);
    send_item(0, 0, 10, 30, 0, 10, 0);
    send_item(-100, 50, 3, 200, -70, 40, 1);
    send_item(0, 0, 0, 1, 0, 0, 0);
    send_item(0, 0, 0, 1, 1, 0, 1);
    send_item(-32768, 0, 32767, 32767, 0, 0, 0);
    send_item(1000, -1000, 1, -1000, 1000, 32767, 1);
    // Hold off until every result is back
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 84 : (ph == 3) ? 9 : 0;
      for (int n = 0; n < 320; n++) send_random();
    end
    drain();
    repeat (80) @(posedge clk);
    if (fail_count == 0)
      $display("two_circle_tangent_segments: match");
    else
      $display("two_circle_tangent_segments: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("two_circle_tangent_segments: mismatch");
    $finish;
  end
endmodule
